/* src/strip_cluster_centroid_defines.svh */
// ----------------------------------------------------------------------------
// Strip cluster centroid assertion macros
// Shared property forms for the concurrent checks of the cluster block.
// ----------------------------------------------------------------------------
`ifndef STRIP_CLUSTER_CENTROID_DEFINES_SVH
`define STRIP_CLUSTER_CENTROID_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/scc_pkg.sv */
// ----------------------------------------------------------------------------
// Strip cluster centroid package
// Widths, defaults, register indexes and shared types of the cluster block.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

   localparam int STRIP_BITS_DEF = 10;
   localparam int ADC_BITS_DEF   = 8;
   localparam int LAYERS_DEF     = 8;

   localparam int LAYER_W    = 3;
   localparam int HIT_NUM_W  = 16;
   localparam int CEN_W      = 18;
   localparam int X_W        = 20;
   localparam int COUNT_W    = 11;
   localparam int PITCH_W    = 10;
   localparam int FRAC_W     = 8;
   localparam int ROUND_HALF = 1 << (FRAC_W - 1);
   localparam int X_MAX      = (1 << (X_W - 1)) - 1;
   localparam int X_MIN      = -(1 << (X_W - 1));
   localparam int DIFF_W     = ((CEN_W > COUNT_W + FRAC_W - 1) ? CEN_W
                                : COUNT_W + FRAC_W - 1) + 1;
   localparam int PROD_W     = DIFF_W + PITCH_W + 1;

   localparam int QUEUE_DEPTH = 4;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = COUNT_W;

   localparam logic [COUNT_W-1:0] STRIP_COUNT_RST = COUNT_W'(1024);
   localparam logic [PITCH_W-1:0] STRIP_PITCH_RST = PITCH_W'(50);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STRIP_COUNT,
      CSR_STRIP_PITCH
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV,
      BK_CEN,
      BK_DIFF,
      BK_MUL,
      BK_FIN
   } bk_state_type;

   typedef struct packed {
      logic empty;
      logic room;
   } qstat_type;

endpackage

`default_nettype wire

/* src/scc_front.sv */
// ----------------------------------------------------------------------------
// Strip cluster front end
// Tracks the open cluster, numbers hits and hands closed clusters to the queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "strip_cluster_centroid_defines.svh"

module scc_front
   import scc_pkg::*;
#(
   parameter int STRIP_BITS = STRIP_BITS_DEF,
   parameter int ADC_BITS   = ADC_BITS_DEF,
   parameter int LAYERS     = LAYERS_DEF,
   parameter int REC_W      = HIT_NUM_W + LAYER_W + 4 * STRIP_BITS + 2 * ADC_BITS + 1
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [LAYER_W-1:0]    in_layer,
   input  wire logic [STRIP_BITS-1:0] in_strip,
   input  wire logic [ADC_BITS-1:0]   in_adc,
   input  wire logic                  in_end_layer,
   input  wire logic                  in_end_event,
   output logic [1:0]                 wr_cnt,
   output logic [REC_W-1:0]           wr_data0,
   output logic [REC_W-1:0]           wr_data1
);

   localparam int CHARGE_W = STRIP_BITS + ADC_BITS;
   localparam int WSUM_W   = 2 * STRIP_BITS + ADC_BITS;

   typedef struct packed {
      logic [HIT_NUM_W-1:0]  hit_number;
      logic [LAYER_W-1:0]    layer;
      logic [STRIP_BITS-1:0] first_strip;
      logic [WSUM_W-1:0]     wsum;
      logic [CHARGE_W-1:0]   charge;
      logic                  last;
   } rec_type;

   logic                  open_ff, open_in;
   logic [LAYER_W-1:0]    layer_ff, layer_in;
   logic [STRIP_BITS-1:0] first_ff, first_in;
   logic [STRIP_BITS-1:0] prev_ff, prev_in;
   logic [STRIP_BITS-1:0] offset_ff, offset_in;
   logic [WSUM_W-1:0]     wsum_ff, wsum_in;
   logic [CHARGE_W-1:0]   charge_ff, charge_in;
   logic [HIT_NUM_W-1:0]  counter_ff, counter_in;

   logic                  layer_ok;
   logic                  adjacent;
   logic                  close_a;
   logic                  close_b;
   logic [CHARGE_W-1:0]   wprod;
   rec_type               rec_a;
   rec_type               rec_b;

   always_comb begin
      layer_ok = 32'(in_layer) < LAYERS;
      adjacent = open_ff && (layer_ff == in_layer) &&
                 ({1'b0, in_strip} == ({1'b0, prev_ff} + 1'b1));

      open_in   = open_ff;
      layer_in  = layer_ff;
      first_in  = first_ff;
      prev_in   = prev_ff;
      offset_in = offset_ff;
      wsum_in   = wsum_ff;
      charge_in = charge_ff;
      close_a   = 1'b0;
      wprod     = '0;

      if (layer_ok) begin
         if (adjacent) begin
            offset_in = offset_ff + 1'b1;
            prev_in   = in_strip;
            wprod     = offset_in * in_adc;
            wsum_in   = wsum_ff + WSUM_W'(wprod);
            charge_in = charge_ff + CHARGE_W'(in_adc);
         end else begin
            close_a   = open_ff;
            open_in   = 1'b1;
            layer_in  = in_layer;
            first_in  = in_strip;
            prev_in   = in_strip;
            offset_in = '0;
            wsum_in   = '0;
            charge_in = CHARGE_W'(in_adc);
         end
      end

      close_b = (in_end_layer || in_end_event) && open_in;
      if (close_b) begin
         open_in = 1'b0;
      end

      rec_a.hit_number  = counter_ff;
      rec_a.layer       = layer_ff;
      rec_a.first_strip = first_ff;
      rec_a.wsum        = wsum_ff;
      rec_a.charge      = charge_ff;
      rec_a.last        = !close_b;

      rec_b.hit_number  = counter_ff + HIT_NUM_W'(close_a);
      rec_b.layer       = layer_in;
      rec_b.first_strip = first_in;
      rec_b.wsum        = wsum_in;
      rec_b.charge      = charge_in;
      rec_b.last        = 1'b1;

      if (in_end_event) begin
         counter_in = '0;
      end else begin
         counter_in = counter_ff + HIT_NUM_W'(close_a) + HIT_NUM_W'(close_b);
      end

      wr_cnt   = accept ? (2'(close_a) + 2'(close_b)) : 2'd0;
      wr_data0 = close_a ? rec_a : rec_b;
      wr_data1 = rec_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff    <= 1'b0;
         layer_ff   <= '0;
         first_ff   <= '0;
         prev_ff    <= '0;
         offset_ff  <= '0;
         wsum_ff    <= '0;
         charge_ff  <= '0;
         counter_ff <= '0;
      end else if (accept) begin
         open_ff    <= open_in;
         layer_ff   <= layer_in;
         first_ff   <= first_in;
         prev_ff    <= prev_in;
         offset_ff  <= offset_in;
         wsum_ff    <= wsum_in;
         charge_ff  <= charge_in;
         counter_ff <= counter_in;
      end
   end

   `SCC_ASSERT_NEXT(a_event_end_clears_count, clock, reset, accept && in_end_event, counter_ff == '0, "hit count not cleared at end of event")
   `SCC_ASSERT_NEXT(a_layer_end_closes, clock, reset, accept && in_end_layer, !open_ff, "cluster still open after end of layer")

endmodule

`default_nettype wire

/* src/scc_queue.sv */
// ----------------------------------------------------------------------------
// Strip cluster hit queue
// Short queue of closed clusters; takes up to two words per cycle, gives one.
// ----------------------------------------------------------------------------
`default_nettype none
`include "strip_cluster_centroid_defines.svh"

module scc_queue
   import scc_pkg::*;
#(
   parameter int REC_W = 64
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [1:0]       wr_cnt,
   input  wire logic [REC_W-1:0] wr_data0,
   input  wire logic [REC_W-1:0] wr_data1,
   input  wire logic             rd_pop,
   output logic [REC_W-1:0]      rd_data,
   output qstat_type             qstat
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [REC_W-1:0] data_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_ptr_next;

   always_comb begin
      wr_ptr_next = wr_ptr_ff + 1'b1;
      wr_ptr_in   = wr_ptr_ff + PTR_W'(wr_cnt);
      rd_ptr_in   = rd_ptr_ff + PTR_W'(rd_pop);
      count_in    = count_ff + CNT_W'(wr_cnt) - CNT_W'(rd_pop);
      rd_data     = data_ff[rd_ptr_ff];
      qstat.empty = (count_ff == '0);
      qstat.room  = (count_ff <= CNT_W'(QUEUE_DEPTH - 2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_cnt != 2'd0) begin
         data_ff[wr_ptr_ff] <= wr_data0;
      end
      if (wr_cnt == 2'd2) begin
         data_ff[wr_ptr_next] <= wr_data1;
      end
   end

   `SCC_ASSERT_IMPLY(a_no_overflow, clock, reset, wr_cnt != 2'd0, ((CNT_W+2)'(count_ff) + (CNT_W+2)'(wr_cnt)) <= (CNT_W+2)'(QUEUE_DEPTH), "queue overflow")
   `SCC_ASSERT_IMPLY(a_no_underflow, clock, reset, rd_pop, count_ff != '0, "pop from empty queue")
   `SCC_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

/* src/scc_back.sv */
// ----------------------------------------------------------------------------
// Strip cluster back end
// Divides out the weighted centroid, converts it to local x and holds the hit.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_back
   import scc_pkg::*;
#(
   parameter int STRIP_BITS = STRIP_BITS_DEF,
   parameter int ADC_BITS   = ADC_BITS_DEF,
   parameter int REC_W      = HIT_NUM_W + LAYER_W + 4 * STRIP_BITS + 2 * ADC_BITS + 1
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [COUNT_W-1:0] strip_count,
   input  wire logic [PITCH_W-1:0] strip_pitch,
   input  wire qstat_type          qstat,
   input  wire logic [REC_W-1:0]   q_data,
   output logic                    q_pop,
   input  wire logic               out_pop,
   output logic                    out_empty,
   output logic [HIT_NUM_W-1:0]    out_hit_number,
   output logic [LAYER_W-1:0]      out_layer,
   output logic [CEN_W-1:0]        out_centroid,
   output logic signed [X_W-1:0]   out_local_x,
   output logic                    out_zero,
   output logic                    out_last
);

   localparam int CHARGE_W = STRIP_BITS + ADC_BITS;
   localparam int WSUM_W   = 2 * STRIP_BITS + ADC_BITS;
   localparam int DIVD_W   = WSUM_W + FRAC_W;
   localparam int STEP_W   = $clog2(DIVD_W);
   localparam logic signed [PROD_W-1:0] XHI = PROD_W'(X_MAX);
   localparam logic signed [PROD_W-1:0] XLO = PROD_W'(X_MIN);
   localparam logic signed [PROD_W-1:0] RND = PROD_W'(ROUND_HALF);

   typedef struct packed {
      logic [HIT_NUM_W-1:0]  hit_number;
      logic [LAYER_W-1:0]    layer;
      logic [STRIP_BITS-1:0] first_strip;
      logic [WSUM_W-1:0]     wsum;
      logic [CHARGE_W-1:0]   charge;
      logic                  last;
   } rec_type;

   bk_state_type             st_ff, st_in;
   rec_type                  rec_ff;
   rec_type                  head;
   logic [CHARGE_W-1:0]      rem_ff;
   logic [DIVD_W-1:0]        acc_ff;
   logic [STEP_W-1:0]        step_ff;
   logic [CEN_W-1:0]         cen_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     valid_ff, valid_in;

   logic [CHARGE_W:0]        rem_t;
   logic                     ge;
   logic [CHARGE_W-1:0]      rem_nx;
   logic                     zero;
   logic [DIVD_W-1:0]        off;
   logic [CEN_W-1:0]         cen_nx;
   logic signed [DIFF_W-1:0] diff_nx;
   logic signed [PITCH_W:0]  pitch_s;
   logic signed [PROD_W-1:0] prod_nx;
   logic signed [PROD_W-1:0] rnd;
   logic signed [PROD_W-1:0] x_full;
   logic signed [X_W-1:0]    x_sat;
   logic                     load_out;
   logic                     out_take;

   always_comb begin
      head     = rec_type'(q_data);
      rem_t    = {rem_ff, acc_ff[DIVD_W-1]};
      ge       = rem_t >= {1'b0, rec_ff.charge};
      rem_nx   = ge ? CHARGE_W'(rem_t - {1'b0, rec_ff.charge}) : CHARGE_W'(rem_t);
      zero     = (rec_ff.charge == '0);
      off      = zero ? '0 : acc_ff;
      cen_nx   = CEN_W'({rec_ff.first_strip, FRAC_W'(0)}) + CEN_W'(off);
      diff_nx  = $signed(DIFF_W'(cen_ff)) -
                 $signed(DIFF_W'({strip_count, (FRAC_W-1)'(0)}));
      pitch_s  = $signed({1'b0, strip_pitch});
      prod_nx  = PROD_W'(diff_ff) * PROD_W'(pitch_s);
      rnd      = prod_ff + RND;
      x_full   = rnd >>> FRAC_W;
      if (x_full > XHI) begin
         x_sat = X_W'(XHI);
      end else if (x_full < XLO) begin
         x_sat = X_W'(XLO);
      end else begin
         x_sat = X_W'(x_full);
      end

      out_take = out_pop && valid_ff;
      st_in    = st_ff;
      q_pop    = 1'b0;
      load_out = 1'b0;
      case (st_ff)
         BK_IDLE: begin
            if (!qstat.empty) begin
               q_pop = 1'b1;
               st_in = BK_DIV;
            end
         end
         BK_DIV: begin
            if (step_ff == STEP_W'(DIVD_W - 1)) begin
               st_in = BK_CEN;
            end
         end
         BK_CEN:  st_in = BK_DIFF;
         BK_DIFF: st_in = BK_MUL;
         BK_MUL:  st_in = BK_FIN;
         BK_FIN: begin
            if (!valid_ff || out_take) begin
               load_out = 1'b1;
               st_in    = BK_IDLE;
            end
         end
         default: st_in = BK_IDLE;
      endcase

      if (load_out) begin
         valid_in = 1'b1;
      end else if (out_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
      out_empty = !valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= BK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         BK_IDLE: begin
            rec_ff  <= head;
            acc_ff  <= {head.wsum, FRAC_W'(0)};
            rem_ff  <= '0;
            step_ff <= '0;
         end
         BK_DIV: begin
            acc_ff  <= {acc_ff[DIVD_W-2:0], ge};
            rem_ff  <= rem_nx;
            step_ff <= step_ff + 1'b1;
         end
         BK_CEN:  cen_ff  <= cen_nx;
         BK_DIFF: diff_ff <= diff_nx;
         BK_MUL:  prod_ff <= prod_nx;
         default: ;
      endcase
      if (load_out) begin
         out_hit_number <= rec_ff.hit_number;
         out_layer      <= rec_ff.layer;
         out_centroid   <= cen_ff;
         out_local_x    <= x_sat;
         out_zero       <= zero;
         out_last       <= rec_ff.last;
      end
   end

endmodule

`default_nettype wire

/* src/strip_cluster_centroid.sv */
// ----------------------------------------------------------------------------
// Strip cluster centroid
// Groups adjacent fired strips into clusters and reports one hit per cluster.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake       Word
//   req_      in         push / full     layer, strip number, adc, end flags
//   rsp_      out        pop / empty     hit number, layer, centroid, x, flags
//   csr_      in         we              index, write data
//
// A pushed strip is taken whenever full is low. The back end works on one
// closed cluster at a time: a one-bit-per-cycle restoring divider, then
// centroid, difference, multiply and finish; a four-word queue sits between.
// Reset is synchronous and clears cluster tracking, numbering and the queue.
// full rises while the queue has room for fewer than two hits.
// ----------------------------------------------------------------------------
`default_nettype none

module strip_cluster_centroid
   import scc_pkg::*;
#(
   parameter int STRIP_BITS = STRIP_BITS_DEF,
   parameter int ADC_BITS   = ADC_BITS_DEF,
   parameter int LAYERS     = LAYERS_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic [LAYER_W-1:0]    req_layer,
   input  wire logic [STRIP_BITS-1:0] req_strip_number,
   input  wire logic [ADC_BITS-1:0]   req_adc,
   input  wire logic                  req_last_in_layer,
   input  wire logic                  req_last_in_event,
   input  wire logic                  rsp_pop,
   output logic                       rsp_empty,
   output logic [HIT_NUM_W-1:0]       rsp_hit_number,
   output logic [LAYER_W-1:0]         rsp_hit_layer,
   output logic [CEN_W-1:0]           rsp_centroid_q8,
   output logic signed [X_W-1:0]      rsp_local_x_um,
   output logic                       rsp_zero_charge,
   output logic                       rsp_last_result,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int REC_W = HIT_NUM_W + LAYER_W + 4 * STRIP_BITS + 2 * ADC_BITS + 1;

   logic [COUNT_W-1:0] strip_count_ff;
   logic [PITCH_W-1:0] strip_pitch_ff;
   logic               accept;
   logic [1:0]         wr_cnt;
   logic [REC_W-1:0]   wr_data0;
   logic [REC_W-1:0]   wr_data1;
   logic [REC_W-1:0]   q_data;
   logic               q_pop;
   qstat_type          qstat;

   assign req_full = !qstat.room;
   assign accept   = req_push && !req_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_count_ff <= STRIP_COUNT_RST;
         strip_pitch_ff <= STRIP_PITCH_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_STRIP_COUNT: strip_count_ff <= COUNT_W'(csr_wdata);
            CSR_STRIP_PITCH: strip_pitch_ff <= csr_wdata[PITCH_W-1:0];
            default: ;
         endcase
      end
   end

   scc_front #(
      .STRIP_BITS (STRIP_BITS),
      .ADC_BITS   (ADC_BITS),
      .LAYERS     (LAYERS),
      .REC_W      (REC_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_layer     (req_layer),
      .in_strip     (req_strip_number),
      .in_adc       (req_adc),
      .in_end_layer (req_last_in_layer),
      .in_end_event (req_last_in_event),
      .wr_cnt       (wr_cnt),
      .wr_data0     (wr_data0),
      .wr_data1     (wr_data1)
   );

   scc_queue #(
      .REC_W (REC_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_cnt   (wr_cnt),
      .wr_data0 (wr_data0),
      .wr_data1 (wr_data1),
      .rd_pop   (q_pop),
      .rd_data  (q_data),
      .qstat    (qstat)
   );

   scc_back #(
      .STRIP_BITS (STRIP_BITS),
      .ADC_BITS   (ADC_BITS),
      .REC_W      (REC_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .strip_count    (strip_count_ff),
      .strip_pitch    (strip_pitch_ff),
      .qstat          (qstat),
      .q_data         (q_data),
      .q_pop          (q_pop),
      .out_pop        (rsp_pop),
      .out_empty      (rsp_empty),
      .out_hit_number (rsp_hit_number),
      .out_layer      (rsp_hit_layer),
      .out_centroid   (rsp_centroid_q8),
      .out_local_x    (rsp_local_x_um),
      .out_zero       (rsp_zero_charge),
      .out_last       (rsp_last_result)
   );

endmodule

`default_nettype wire
